### rtl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the symbol lookup for the Base64 stream encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

    localparam logic [7:0] PAD_CHAR       = 8'h3D;  // '='
    localparam logic [7:0] NL_CHAR        = 8'h0A;  // newline
    localparam logic [7:0] MIN_LINE_LEN   = 8'd4;
    localparam logic [7:0] LINE_LEN_RESET = 8'd76;
    localparam int         CMD_DEPTH_DEF  = 2;
    localparam int         CFG_IDX_W      = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WRAP_ENABLE = 1'b0,
        CFG_LINE_LENGTH = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_end;
    } out_item_t;

    // One encode job handed from the front end to the back end
    typedef struct packed {
        logic [23:0] grp;     // up to three bytes, first byte in the top bits
        logic [2:0]  ndata;   // data characters to emit: 2, 3 or 4
        logic [1:0]  npad;    // pad characters after them
        logic        last;    // group closes the message
    } cmd_t;

    // Standard 64-symbol alphabet
    function automatic logic [7:0] b64_symbol(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)
            return 8'(8'h41 + w);
        else if (v < 6'd52)
            return 8'(8'h61 + w - 8'd26);
        else if (v < 6'd62)
            return 8'(8'h30 + w - 8'd52);
        else if (v == 6'd62)
            return 8'h2B;
        else
            return 8'h2F;
    endfunction

endpackage

`default_nettype wire

### rtl/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Collects message bytes into groups and issues encode jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire b64e_pkg::in_item_t item,
    output logic                   full,
    input  wire logic              q_full,
    output logic                   cmd_wr,
    output b64e_pkg::cmd_t         cmd
);
    import b64e_pkg::*;

    logic [15:0] pending_reg, pending_next;
    logic [1:0]  count_reg, count_next;
    logic        accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    always_comb
    begin
        pending_next = pending_reg;
        count_next   = count_reg;
        cmd_wr       = 1'b0;
        cmd          = '0;
        cmd.last     = item.end_of_message;
        if (accept)
        begin
            if (count_reg == 2'd2)
            begin
                cmd_wr     = 1'b1;
                cmd.grp    = {pending_reg, item.data_byte};
                cmd.ndata  = 3'd4;
                cmd.npad   = 2'd0;
                count_next = 2'd0;
            end
            else if (!item.end_of_message)
            begin
                if (count_reg == 2'd0)
                    pending_next = {item.data_byte, 8'h00};
                else
                    pending_next = {pending_reg[15:8], item.data_byte};
                count_next = count_reg + 2'd1;
            end
            else if (count_reg == 2'd1)
            begin
                cmd_wr     = 1'b1;
                cmd.grp    = {pending_reg[15:8], item.data_byte, 8'h00};
                cmd.ndata  = 3'd3;
                cmd.npad   = 2'd1;
                count_next = 2'd0;
            end
            else
            begin
                cmd_wr     = 1'b1;
                cmd.grp    = {item.data_byte, 16'h0000};
                cmd.ndata  = 3'd2;
                cmd.npad   = 2'd2;
                count_next = 2'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
            count_reg   <= count_next;
        end
    end

endmodule

`default_nettype wire

### rtl/b64e_cmd_queue.sv
// ----------------------------------------------------------------------------
// b64e_cmd_queue
// Short job queue between the front and back ends; head shown directly.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_cmd_queue #(
    parameter int DEPTH = b64e_pkg::CMD_DEPTH_DEF   // power of two, >= 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire b64e_pkg::cmd_t wr_cmd,
    input  wire logic           rd_en,
    output b64e_pkg::cmd_t      rd_cmd,
    output logic                full,
    output logic                empty
);
    import b64e_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + CNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

### rtl/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Character sequencer: one character per cycle unless stalled, line wrapping, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wrap_enable,
    input  wire logic [7:0]     line_len,
    input  wire b64e_pkg::cmd_t cmd,
    input  wire logic           cmd_valid,
    output logic                cmd_pop,
    input  wire logic           pop,
    output logic                empty,
    output b64e_pkg::out_item_t result
);
    import b64e_pkg::*;

    logic [2:0] idx_reg, idx_next;     // data characters sent from the job
    logic [1:0] pad_reg, pad_next;     // pads sent from the job
    logic       nl_reg, nl_next;       // newline owed before the next char
    logic [7:0] pos_reg, pos_next;     // data characters on current line
    out_item_t  out_reg;
    logic       out_valid_reg;

    logic       fire, done, nl_ok;
    logic [7:0] lim, pos_inc, ch;
    logic [5:0] six;

    assign lim     = (line_len < MIN_LINE_LEN) ? MIN_LINE_LEN : line_len;
    assign pos_inc = pos_reg + 8'd1;
    assign fire    = cmd_valid && (!out_valid_reg || pop);
    // no newline after the closing character of a full final group
    assign nl_ok   = !(cmd.last && idx_reg == 3'd3);

    always_comb
    begin
        case (idx_reg[1:0])
            2'd0:    six = cmd.grp[23:18];
            2'd1:    six = cmd.grp[17:12];
            2'd2:    six = cmd.grp[11:6];
            default: six = cmd.grp[5:0];
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        pad_next = pad_reg;
        nl_next  = nl_reg;
        pos_next = pos_reg;
        ch       = PAD_CHAR;
        if (nl_reg)
        begin
            ch      = NL_CHAR;
            nl_next = 1'b0;
        end
        else if (idx_reg < cmd.ndata)
        begin
            ch       = b64_symbol(six);
            idx_next = idx_reg + 3'd1;
            if (wrap_enable)
            begin
                if (pos_inc >= lim)
                begin
                    pos_next = '0;
                    nl_next  = nl_ok;
                end
                else
                    pos_next = pos_inc;
            end
        end
        else
            pad_next = pad_reg + 2'd1;
        done = !nl_next && (idx_next == cmd.ndata) && (pad_next == cmd.npad);
        if (done && cmd.last)
            pos_next = '0;
    end

    assign cmd_pop = fire && done;
    assign empty   = !out_valid_reg;
    assign result  = out_reg;

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_reg.out_char <= ch;
            out_reg.run_end  <= done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            pad_reg       <= '0;
            nl_reg        <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                pos_reg <= pos_next;
                if (done)
                begin
                    idx_reg <= '0;
                    pad_reg <= '0;
                    nl_reg  <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_next;
                    pad_reg <= pad_next;
                    nl_reg  <= nl_next;
                end
            end
            if (fire)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

### rtl/base64_stream_encoder.sv
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming Base64 encoder with optional line wrapping at a set line length.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                        Transfer when
//  -------   ----------------------------   ----------------------------
//  input     push, full, item               push high, full low
//  result    empty, pop, result             pop high, empty low
//  config    cfg_write, cfg_index, cfg_data cfg_write high
//
//  One character per cycle while results are popped: a group of three bytes
//  gives four characters, or five with a newline.
//  A group's first character passes through the job queue write, then the
//  result register, after the transfer of the byte completing it.
//  full rises only when the job queue is full, e.g. behind a stalled pop.
//  Reset clears the control state; wrap enable resets to 0, line length to 76.
//
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_encoder #(
    parameter int CMD_DEPTH = b64e_pkg::CMD_DEPTH_DEF   // power of two, >= 2
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input bytes
    input  wire logic                              push,
    output logic                                   full,
    input  wire b64e_pkg::in_item_t                item,
    // encoded characters
    output logic                                   empty,
    input  wire logic                              pop,
    output b64e_pkg::out_item_t                    result,
    // configuration
    input  wire logic                              cfg_write,
    input  wire logic [b64e_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [7:0]                        cfg_data
);
    import b64e_pkg::*;

    logic       wrap_enable_reg;
    logic [7:0] line_len_reg;

    cmd_t       q_wr_cmd, q_rd_cmd;
    logic       q_wr, q_rd, q_full, q_empty;

    // Config registers; to be written only while the block is idle, which it does not enforce
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_enable_reg <= 1'b0;
            line_len_reg    <= LINE_LEN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_WRAP_ENABLE: wrap_enable_reg <= cfg_data[0];
                CFG_LINE_LENGTH: line_len_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Front end: group assembly, classifies full and final partial groups
    b64e_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .q_full (q_full),
        .cmd_wr (q_wr),
        .cmd    (q_wr_cmd)
    );

    // Decouples byte intake from character output
    b64e_cmd_queue #(
        .DEPTH (CMD_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_wr),
        .wr_cmd (q_wr_cmd),
        .rd_en  (q_rd),
        .rd_cmd (q_rd_cmd),
        .full   (q_full),
        .empty  (q_empty)
    );

    // Back end: character sequencing, newline insertion, result register
    b64e_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .wrap_enable (wrap_enable_reg),
        .line_len    (line_len_reg),
        .cmd         (q_rd_cmd),
        .cmd_valid   (!q_empty),
        .cmd_pop     (q_rd),
        .pop         (pop),
        .empty       (empty),
        .result      (result)
    );

endmodule

`default_nettype wire

### rtl/b64e_checker.sv
// ----------------------------------------------------------------------------
// b64e_checker
// Port-level checks on the result stream of the Base64 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module b64e_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                empty,
    input  wire logic                pop,
    input  wire b64e_pkg::out_item_t result
);
    import b64e_pkg::*;

    // a waiting result holds until transferred
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed while stalled");

    // a pad that is not the last result is followed by another pad
    a_pad_run: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && result.out_char == PAD_CHAR && !result.run_end)
        |=> (empty || result.out_char == PAD_CHAR))
        else $error("pad followed by non-pad");

    // never two newlines in a row
    a_no_double_nl: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && result.out_char == NL_CHAR)
        |=> (empty || result.out_char != NL_CHAR))
        else $error("two newlines in a row");

    // a pad never opens a run of results
    a_pad_after: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && result.run_end)
        |=> (empty || result.out_char != PAD_CHAR))
        else $error("pad at start of a run");

endmodule

bind base64_stream_encoder b64e_checker u_b64e_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

`default_nettype wire

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Base64 stream encoder. Message bytes are pushed
// through the input channel, and every encoded character, pad and newline
// popped from the result register is compared against a cycle-free model of the
// encoder kept in a small scoreboard class.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import b64e_pkg::*;

    // Cycles with no transfer at all before the run is declared hung. The
    // slowest legal stretch is a run of sender or receiver stalls at 84 % idling.
    localparam int unsigned STALL_LIMIT = 3000;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks held bytes, line position and register settings, and
    // keeps the characters still owed by the encoder in arrival order.
    // ------------------------------------------------------------------------
    class b64_char_scoreboard;
        bit          wrap_on;
        logic [7:0]  line_len;
        logic [15:0] held_bytes;    // first held byte in the upper half
        int unsigned held_count;
        logic [7:0]  line_pos;
        out_item_t   due_chars[$];
        string       alphabet;
        int unsigned errors;
        int unsigned bytes_in;
        int unsigned messages;
        int unsigned chars_out;
        int unsigned newlines;
        int unsigned pads;
        int unsigned reg_writes;

        function new();
            alphabet   = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
            wrap_on    = 1'b0;
            line_len   = LINE_LEN_RESET;
            held_bytes = '0;
            held_count = 0;
            line_pos   = '0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [7:0] value);
            reg_writes++;
            if (idx == CFG_WRAP_ENABLE)
                wrap_on = value[0];
            else
                line_len = value;
        endfunction

        function void owe_char(logic [7:0] c);
            out_item_t r;
            r.out_char = c;
            r.run_end  = 1'b0;
            due_chars.insert(due_chars.size(), r);
        endfunction

        // One data character; a newline may follow when it closes a line
        function void owe_symbol(logic [5:0] six, bit newline_ok);
            logic [7:0] lim;
            lim = (line_len < MIN_LINE_LEN) ? MIN_LINE_LEN : line_len;
            owe_char(alphabet[six]);
            if (wrap_on)
            begin
                line_pos = line_pos + 8'd1;
                // >= so that a line length lowered mid-line breaks at once
                if (line_pos >= lim)
                begin
                    if (newline_ok)
                        owe_char(NL_CHAR);
                    line_pos = '0;
                end
            end
        endfunction

        function void note_byte(in_item_t it);
            logic [23:0] grp;
            int unsigned n_before;
            out_item_t   tail;
            n_before = due_chars.size();
            bytes_in++;
            if (held_count == 2)
            begin
                grp = {held_bytes, it.data_byte};
                owe_symbol(grp[23:18], 1'b1);
                owe_symbol(grp[17:12], 1'b1);
                owe_symbol(grp[11:6], 1'b1);
                // no newline after the closing character of a message
                owe_symbol(grp[5:0], !it.end_of_message);
                held_bytes = '0;
                held_count = 0;
            end
            else if (!it.end_of_message)
            begin
                if (held_count == 0)
                    held_bytes = {it.data_byte, 8'h00};
                else
                    held_bytes[7:0] = it.data_byte;
                held_count++;
            end
            else if (held_count == 1)
            begin
                grp = {held_bytes[15:8], it.data_byte, 8'h00};
                owe_symbol(grp[23:18], 1'b1);
                owe_symbol(grp[17:12], 1'b1);
                owe_symbol(grp[11:6], 1'b1);
                owe_char(PAD_CHAR);
            end
            else
            begin
                grp = {it.data_byte, 16'h0000};
                owe_symbol(grp[23:18], 1'b1);
                owe_symbol(grp[17:12], 1'b1);
                owe_char(PAD_CHAR);
                owe_char(PAD_CHAR);
            end

            if (it.end_of_message)
            begin
                held_bytes = '0;
                held_count = 0;
                line_pos   = '0;
                messages++;
            end

            // flag the final character caused by this byte
            if (due_chars.size() > n_before)
            begin
                tail = due_chars[due_chars.size() - 1];
                tail.run_end = 1'b1;
                due_chars[due_chars.size() - 1] = tail;
            end
        endfunction

        function void check_char(out_item_t got);
            out_item_t want;
            if (due_chars.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, got out_char %02h run_end %0b",
                         $time, got.out_char, got.run_end);
                return;
            end
            want = due_chars.pop_front();
            chars_out++;
            if (want.out_char == NL_CHAR)
                newlines++;
            if (want.out_char == PAD_CHAR)
                pads++;
            if (got.out_char !== want.out_char)
            begin
                errors++;
                $display("%0t: out_char mismatch: expected %02h, got %02h",
                         $time, want.out_char, got.out_char);
            end
            if (got.run_end !== want.run_end)
            begin
                errors++;
                $display("%0t: run_end mismatch on %02h: expected %0b, got %0b",
                         $time, want.out_char, want.run_end, got.run_end);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and block ports; every bench-driven signal starts from a known value
    // ------------------------------------------------------------------------
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 push      = 1'b0;
    logic                 full;
    in_item_t             item      = '0;
    logic                 empty;
    logic                 pop       = 1'b0;
    out_item_t            result;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;

    // idle chances in percent for each side, changed between phases
    int unsigned tx_idle_pct = 17;
    int unsigned rx_idle_pct = 84;

    int unsigned quiet_cycles = 0;

    b64_char_scoreboard sb = new();

    always #6 clk = ~clk;

    base64_stream_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Result side: check each popped character, then pick pop for the next
    // cycle. Values read here are the ones present before the edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            sb.check_char(result);
        pop <= rst_n && ($urandom_range(99) >= rx_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Watchdog: any transfer or register write counts as progress
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d characters still owed",
                     $time, STALL_LIMIT, sb.due_chars.size());
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Input side. push stays high from one byte to the next unless the
    // sender decides to idle first, so it never gets two updates in a step.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input bit last);
        in_item_t it;
        it.data_byte      = b;
        it.end_of_message = last;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_byte(it);
    endtask

    task automatic send_msg(input logic [7:0] bytes[$]);
        foreach (bytes[i])
            send_byte(bytes[i], i == bytes.size() - 1);
    endtask

    // Stop pushing and let every owed character drain. The extra cycles cover
    // a byte still in flight that owes nothing (first or second of a group).
    task automatic settle();
        push <= 1'b0;
        while (sb.due_chars.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Both registers in back-to-back writes; only legal while idle
    task automatic apply_settings(input bit wrap, input logic [7:0] len);
        cfg_write <= 1'b1;
        cfg_index <= CFG_WRAP_ENABLE;
        cfg_data  <= {7'b0, wrap};
        @(posedge clk);
        sb.write_reg(CFG_WRAP_ENABLE, {7'b0, wrap});
        cfg_index <= CFG_LINE_LENGTH;
        cfg_data  <= len;
        @(posedge clk);
        sb.write_reg(CFG_LINE_LENGTH, len);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [7:0]  msg[$];
        bit          wrap_tab[6];
        logic [7:0]  len_tab[6];
        int unsigned max_tab[6];
        int unsigned msg_left;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset settings (wrapping off): one- and two-byte tails
        // with their pads, then full groups hitting all-ones and '+' symbols.
        msg = '{8'h00};
        send_msg(msg);
        msg = '{8'hFF, 8'hFF};
        send_msg(msg);
        msg = '{8'hFB, 8'hEF, 8'hBE};
        send_msg(msg);
        msg = '{8'hFF, 8'hFF, 8'hFF};
        send_msg(msg);

        // Shortest line: a single full final group fills the line exactly and
        // must not be followed by a newline; two groups break once between.
        settle();
        apply_settings(1'b1, 8'd4);
        msg = '{8'h4D, 8'h61, 8'h6E};
        send_msg(msg);
        msg = '{8'h00, 8'h10, 8'h83, 8'h10, 8'h51, 8'h87};
        send_msg(msg);

        // Line length of zero behaves as the minimum of four
        settle();
        apply_settings(1'b1, 8'd0);
        msg = '{8'h12, 8'h34, 8'h56, 8'h78, 8'h9A};
        send_msg(msg);

        // Partial final group whose last data character ends a line: the
        // newline still goes out, ahead of the pads.
        settle();
        apply_settings(1'b1, 8'd6);
        msg = '{8'hAB, 8'hCD, 8'hEF, 8'h01};
        send_msg(msg);

        // Random phases. A phase may end part-way through a message, so the
        // next settings take effect mid-line (shorter line, wrap toggled).
        wrap_tab = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        len_tab  = '{8'd4, 8'd255, 8'd9, 8'd76, 8'd3, 8'd4};
        len_tab[5] = 8'($urandom_range(4, 20));
        max_tab  = '{12, 60, 30, 20, 10, 25};
        msg_left = 0;
        for (int p = 0; p < 6; p++)
        begin
            settle();
            if (p == 2)
            begin
                tx_idle_pct = 84;
                rx_idle_pct = 17;
            end
            else if (p == 4)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            apply_settings(wrap_tab[p], len_tab[p]);
            repeat ($urandom_range(24, 32))
            begin
                if (msg_left == 0)
                    msg_left = $urandom_range(1, max_tab[p]);
                send_byte(8'($urandom_range(255)), msg_left == 1);
                msg_left--;
            end
        end

        settle();

        $display("Run covered %0d bytes in %0d finished messages over %0d register writes,",
                 sb.bytes_in, sb.messages, sb.reg_writes);
        $display("with %0d characters checked, %0d of them newlines and %0d pads.",
                 sb.chars_out, sb.newlines, sb.pads);
        if (sb.errors == 0 && sb.due_chars.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
